// ===== rtl/rcfd_pkg.sv =====
// Package for the RC receiver frame decoder: preamble codes, field widths
// and the item types of the byte and channel streams. No dependencies.
`default_nettype none
package rcfd_pkg;

	localparam int unsigned CHANNELS_DEF = 7;
	localparam int unsigned CHANNELS_MAX = 16;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned IDX_W   = 4;
	localparam int unsigned VALUE_W = 10;
	localparam int unsigned FRAME_W = 32;
	localparam int unsigned HI_W    = VALUE_W - BYTE_W;

	localparam logic [BYTE_W-1:0] PREAMBLE_FIRST  = 8'h03;
	localparam logic [BYTE_W-1:0] PREAMBLE_SECOND = 8'h01;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]   channel_index;
		logic [VALUE_W-1:0] channel_value;
		logic [FRAME_W-1:0] frame_number;
		logic               last_channel;
	} out_item_t;

endpackage
`default_nettype wire

// ===== rtl/rcfd_stream_if.sv =====
// Valid/ready stream interface for the RC receiver frame decoder.
// The item type is a parameter; the decoder uses the types of rcfd_pkg.
`default_nettype none
interface rcfd_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/rc_receiver_frame_decoder.sv =====
// RC receiver frame decoder: takes one serial byte per item, hunts for the
// preamble 0x03 0x01, then stores 2*CHANNELS payload bytes as CHANNELS
// 10-bit channel values in a small synchronous memory (one entry per
// channel, written when the low byte of a pair arrives). A byte is taken
// whenever the decoder is idle. When the last payload byte completes a frame,
// the frame count advances and the channel values are read back one memory
// entry at a time: each channel is read, then loaded into the output register,
// which waits while the result side stalls, and no byte is taken during the
// read-back. Depends on rcfd_pkg and rcfd_stream_if.
`default_nettype none
module rc_receiver_frame_decoder #(
	parameter int unsigned CHANNELS = rcfd_pkg::CHANNELS_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	rcfd_stream_if.sink         bytes,
	rcfd_stream_if.source       chans
);

	localparam int unsigned CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int unsigned PH_W    = $clog2(2 * CHANNELS + 2);
	localparam int unsigned IdxW    = rcfd_pkg::IDX_W;
	localparam int unsigned ValW    = rcfd_pkg::VALUE_W;
	localparam int unsigned HiW     = rcfd_pkg::HI_W;
	localparam int unsigned FrameW  = rcfd_pkg::FRAME_W;
	localparam logic [PH_W-1:0] PhHunt   = PH_W'(0);
	localparam logic [PH_W-1:0] PhSecond = PH_W'(1);
	localparam logic [PH_W-1:0] PhLast   = PH_W'(2 * CHANNELS + 1);
	localparam logic [CH_W-1:0] ChLast   = CH_W'(CHANNELS - 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_FETCH = 3'b010,
		ST_LOAD  = 3'b100
	} state_t;

	state_t                       state_q;
	logic [PH_W-1:0]              phase_q;
	logic [HiW-1:0]               hi_q;
	logic [FrameW-1:0]            frames_q;
	logic [CH_W-1:0]              ch_q;
	logic [ValW-1:0]              rd_data_q;
	logic [ValW-1:0]              mem [CHANNELS];
	logic                         out_valid_q;
	rcfd_pkg::out_item_t          out_q;

	logic                         in_fire;
	logic [rcfd_pkg::BYTE_W-1:0]  rx;
	logic                         pair_done;
	logic [CH_W-1:0]              wr_ch;
	logic                         frame_done;
	logic                         out_free;
	logic                         load_out;

	assign in_fire    = bytes.valid && bytes.ready;
	assign rx         = bytes.data.rx_byte;
	// odd phase past the preamble holds the low byte of a pair
	assign pair_done  = in_fire && phase_q[0] && (phase_q != PhSecond);
	assign wr_ch      = CH_W'((phase_q >> 1) - PH_W'(1));
	assign frame_done = pair_done && (phase_q == PhLast);
	assign out_free   = !out_valid_q || chans.ready;
	assign load_out   = (state_q == ST_LOAD) && out_free;

	assign bytes.ready = (state_q == ST_IDLE);
	assign chans.valid = out_valid_q;
	assign chans.data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PhHunt;
			frames_q <= '0;
		end else if (in_fire) begin
			priority if (phase_q == PhHunt) begin
				phase_q <= (rx == rcfd_pkg::PREAMBLE_FIRST) ? PhSecond : PhHunt;
			end else if (phase_q == PhSecond) begin
				phase_q <= (rx == rcfd_pkg::PREAMBLE_SECOND) ? PH_W'(2) : PhHunt;
			end else if (phase_q == PhLast) begin
				phase_q  <= PhHunt;
				frames_q <= frames_q + FrameW'(1);
			end else if (phase_q < PhLast) begin
				phase_q <= phase_q + PH_W'(1);
			end else begin
				phase_q <= PhHunt;
			end
		end
	end

	// hold the high bits of a pair until its low byte arrives
	always_ff @(posedge clk) begin
		if (in_fire && !phase_q[0]) begin
			hi_q <= rx[HiW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pair_done) begin
			mem[wr_ch] <= {hi_q, rx};
		end
		if (state_q == ST_FETCH) begin
			rd_data_q <= mem[ch_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (chans.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (frame_done) begin
						state_q <= ST_FETCH;
						ch_q    <= '0;
					end
				end
				ST_FETCH: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (out_free) begin
						if (ch_q == ChLast) begin
							state_q <= ST_IDLE;
						end else begin
							ch_q    <= ch_q + CH_W'(1);
							state_q <= ST_FETCH;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q.channel_index <= IdxW'(ch_q);
			out_q.channel_value <= rd_data_q;
			out_q.frame_number  <= frames_q;
			out_q.last_channel  <= (ch_q == ChLast);
		end
	end

endmodule
`default_nettype wire

// ===== tb/rcfd_checker.sv =====
// Scoreboard for the RC receiver frame decoder: watches the byte and channel
// streams, predicts channel values from accepted bytes and compares them.
// Depends on rcfd_pkg.
`default_nettype none
module rcfd_checker #(
	parameter int unsigned CHANNELS = rcfd_pkg::CHANNELS_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                byte_valid,
	input  wire logic                byte_ready,
	input  wire rcfd_pkg::in_item_t  byte_data,
	input  wire logic                chan_valid,
	input  wire logic                chan_ready,
	input  wire rcfd_pkg::out_item_t chan_data,
	output int unsigned              failures,
	output int unsigned              pending,
	output int unsigned              values_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned PAYLOAD_LEN = 2 * CHANNELS;
	localparam logic [5:0] PH_HUNT = 6'd0;
	localparam logic [5:0] PH_SECOND = 6'd1;
	localparam logic [5:0] PH_FIRST_PAYLOAD = 6'd2;
	localparam int unsigned SHOWN_MAX = 10;

	logic [5:0]          frame_phase;
	logic [7:0]          payload [PAYLOAD_LEN];
	logic [31:0]         frames_done;
	rcfd_pkg::out_item_t expected_chans [$];
	rcfd_pkg::out_item_t oldest;
	int unsigned         mismatch_cnt = 0;

	initial begin
		failures = 0;
		pending = 0;
		values_checked = 0;
	end

	task automatic decode_rx_byte(input logic [7:0] b);
		int unsigned         slot;
		rcfd_pkg::out_item_t chan;
		if (frame_phase == PH_HUNT) begin
			frame_phase = (b == rcfd_pkg::PREAMBLE_FIRST) ? PH_SECOND : PH_HUNT;
		end else if (frame_phase == PH_SECOND) begin
			// a wrong second byte drops to hunting, even if it is the first code
			frame_phase = (b == rcfd_pkg::PREAMBLE_SECOND) ? PH_FIRST_PAYLOAD : PH_HUNT;
		end else begin
			slot = 32'(frame_phase - PH_FIRST_PAYLOAD);
			if (slot >= PAYLOAD_LEN) begin
				frame_phase = PH_HUNT;
			end else begin
				payload[slot] = b;
				if (slot == PAYLOAD_LEN - 1) begin
					frame_phase = PH_HUNT;
					frames_done = frames_done + 32'd1;
					for (int ch = 0; ch < CHANNELS; ch++) begin
						chan.channel_index = rcfd_pkg::IDX_W'(ch);
						chan.channel_value = {payload[2*ch][rcfd_pkg::HI_W-1:0],
							payload[2*ch+1]};
						chan.frame_number = frames_done;
						chan.last_channel = (ch == CHANNELS - 1);
						expected_chans.push_back(chan);
					end
				end else begin
					frame_phase = frame_phase + 6'd1;
				end
			end
		end
	endtask

	task automatic note_mismatch(input string what, input rcfd_pkg::out_item_t exp_v,
			input rcfd_pkg::out_item_t act_v);
		mismatch_cnt++;
		if (mismatch_cnt <= SHOWN_MAX)
			$display({"%0t: %s: expected idx=%0d val=%0d frame=%0d last=%0b,",
				" got idx=%0d val=%0d frame=%0d last=%0b"},
				$time, what, exp_v.channel_index, exp_v.channel_value, exp_v.frame_number,
				exp_v.last_channel, act_v.channel_index, act_v.channel_value,
				act_v.frame_number, act_v.last_channel);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_phase = PH_HUNT;
			frames_done = '0;
			foreach (payload[i]) payload[i] = '0;
			expected_chans.delete();
			mismatch_cnt = 0;
			values_checked = 0;
		end else begin
			if (chan_valid && chan_ready) begin
				values_checked++;
				if (expected_chans.size() == 0) begin
					note_mismatch("channel value with none expected", '0, chan_data);
				end else begin
					oldest = expected_chans.pop_front();
					if (chan_data.channel_index !== oldest.channel_index ||
							chan_data.channel_value !== oldest.channel_value ||
							chan_data.frame_number !== oldest.frame_number ||
							chan_data.last_channel !== oldest.last_channel)
						note_mismatch("channel value mismatch", oldest, chan_data);
				end
			end
			if (byte_valid && byte_ready)
				decode_rx_byte(byte_data.rx_byte);
		end
		pending = unsigned'(expected_chans.size());
		// anything still waiting counts against the run when it is read at the end
		failures = mismatch_cnt + pending;
	end
endmodule
`default_nettype wire

// ===== tb/rc_receiver_frame_decoder_tb.sv =====
// Top of the RC receiver frame decoder testbench: clock, reset, byte stimulus
// and channel-side backpressure, verdict. Depends on rcfd_pkg, rcfd_stream_if
// and rcfd_checker.
`default_nettype none
module rc_receiver_frame_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned CHANNELS = rcfd_pkg::CHANNELS_DEF;
	localparam int unsigned PAYLOAD_LEN = 2 * CHANNELS;
	localparam int unsigned DIRECTED_ITEMS = 21;
	localparam int unsigned RANDOM_ITEMS = 60;
	localparam int unsigned TAIL_ITEMS = 40;
	localparam int unsigned LONG_HOLD = 200;
	localparam int unsigned DRAIN_LIMIT = 4000;
	localparam int unsigned SETTLE_CYCLES = 4 * CHANNELS + 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	bit          src_idle_en;
	bit          sink_idle_en;
	bit          hold_req;
	int unsigned hold_left;
	int unsigned bytes_sent;
	int unsigned tail_start;
	int unsigned drain_wait;
	int unsigned failures;
	int unsigned pending;
	int unsigned values_checked;

	rcfd_stream_if #(.T(rcfd_pkg::in_item_t)) byte_if ();
	rcfd_stream_if #(.T(rcfd_pkg::out_item_t)) chans_if ();

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	rc_receiver_frame_decoder #(
		.CHANNELS(CHANNELS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.bytes(byte_if),
		.chans(chans_if)
	);

	rcfd_checker #(
		.CHANNELS(CHANNELS)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_if.valid),
		.byte_ready(byte_if.ready),
		.byte_data(byte_if.data),
		.chan_valid(chans_if.valid),
		.chan_ready(chans_if.ready),
		.chan_data(chans_if.data),
		.failures(failures),
		.pending(pending),
		.values_checked(values_checked)
	);

	initial begin
		#1_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// channel side: random stalls, plus one long hold-off on request
	initial begin
		chans_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!arst_n) begin
				chans_if.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				chans_if.ready <= 1'b0;
			end else if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				chans_if.ready <= 1'b0;
			end else if (sink_idle_en && $urandom_range(0, 6) == 0) begin
				hold_left = $urandom_range(0, 5);
				chans_if.ready <= 1'b0;
			end else begin
				chans_if.ready <= 1'b1;
			end
		end
	end

	function automatic logic [7:0] rand_byte();
		unique case ($urandom_range(0, 7))
			0: return rcfd_pkg::PREAMBLE_FIRST;
			1: return rcfd_pkg::PREAMBLE_SECOND;
			2: return 8'h00;
			3: return 8'hFF;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic push_byte(input logic [7:0] b);
		if (src_idle_en && $urandom_range(0, 5) == 0) begin
			byte_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		byte_if.valid <= 1'b1;
		byte_if.data <= rcfd_pkg::in_item_t'(b);
		do @(posedge clk); while (!byte_if.ready);
		bytes_sent++;
		@(negedge clk);
	endtask

	task automatic send_frame();
		push_byte(rcfd_pkg::PREAMBLE_FIRST);
		push_byte(rcfd_pkg::PREAMBLE_SECOND);
		repeat (PAYLOAD_LEN) push_byte(rand_byte());
	endtask

	// stray bytes between frames; may break or shift the next frame
	task automatic send_noise();
		repeat ($urandom_range(1, 4)) push_byte(rand_byte());
	endtask

	task automatic wait_drained();
		byte_if.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
	endtask

	initial begin
		byte_if.valid = 1'b0;
		byte_if.data = '0;
		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		bytes_sent = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// one frame with extreme pairs, then preamble faults
		push_byte(rcfd_pkg::PREAMBLE_FIRST);
		push_byte(rcfd_pkg::PREAMBLE_SECOND);
		push_byte(8'hFF); push_byte(8'hFF);
		push_byte(8'h00); push_byte(8'h00);
		push_byte(8'h03); push_byte(8'h00);
		push_byte(8'hFC); push_byte(8'hFF);
		push_byte(8'h01); push_byte(8'h03);
		push_byte(8'h02); push_byte(8'h80);
		push_byte(8'h80); push_byte(8'h01);
		// first code twice: the second one drops to hunting, so 0x01 is ignored
		push_byte(rcfd_pkg::PREAMBLE_FIRST);
		push_byte(rcfd_pkg::PREAMBLE_FIRST);
		push_byte(rcfd_pkg::PREAMBLE_SECOND);
		push_byte(rcfd_pkg::PREAMBLE_FIRST);
		push_byte(8'h00);
		wait_drained();

		src_idle_en = 1'b1;
		sink_idle_en = 1'b1;
		while (bytes_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
			if ($urandom_range(0, 3) == 0)
				send_noise();
			send_frame();
		end
		wait_drained();

		// keep offering frames while the channel side holds off
		hold_req = 1'b1;
		repeat (3) send_frame();
		wait_drained();

		src_idle_en = 1'b0;
		sink_idle_en = 1'b0;
		tail_start = bytes_sent;
		while (bytes_sent < tail_start + TAIL_ITEMS) begin
			if ($urandom_range(0, 4) == 0)
				send_noise();
			send_frame();
		end
		byte_if.valid <= 1'b0;

		drain_wait = 0;
		while (pending != 0 && drain_wait < DRAIN_LIMIT) begin
			@(negedge clk);
			drain_wait++;
		end
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("covered %0d bytes: extreme pairs, preamble faults, noisy random frames",
			bytes_sent);
		$display("and a long channel-side stall; %0d channel values compared", values_checked);
		if (failures == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end
endmodule
`default_nettype wire
